### hw/rtl/tet_pkg.sv
// ----------------------------------------------------------------------------
// tet_pkg: shared types and constants for the timed event table
// Field widths, item layout offsets, operation and status codes, result record.
// ----------------------------------------------------------------------------
`default_nettype none

package tet_pkg;

  // table size default and dispatch limit per poll
  localparam int SLOTS_DEF = 16;
  localparam int MAX_RES   = 16;
  localparam int N_W       = $clog2(MAX_RES + 1);

  // field widths
  localparam int KIND_W   = 2;
  localparam int NOW_W    = 32;
  localparam int WAIT_W   = 31;
  localparam int ID_W     = 16;
  localparam int HANDLE_W = 4;
  localparam int STATUS_W = 3;

  // input tdata layout, lowest bit first
  localparam int IN_NOW_LO    = 0;
  localparam int IN_WAIT_LO   = IN_NOW_LO + NOW_W;
  localparam int IN_TGT_LO    = IN_WAIT_LO + WAIT_W;
  localparam int IN_TAG_LO    = IN_TGT_LO + ID_W;
  localparam int IN_IMM_LO    = IN_TAG_LO + ID_W;
  localparam int IN_HDL_LO    = IN_IMM_LO + 1;
  localparam int IN_BITS      = IN_HDL_LO + HANDLE_W;
  localparam int IN_DATA_W    = ((IN_BITS + 7) / 8) * 8;

  // output tdata layout, lowest bit first
  localparam int OUT_HDL_LO   = 0;
  localparam int OUT_TGT_LO   = OUT_HDL_LO + HANDLE_W;
  localparam int OUT_TAG_LO   = OUT_TGT_LO + ID_W;
  localparam int OUT_BITS     = OUT_TAG_LO + ID_W;
  localparam int OUT_DATA_W   = ((OUT_BITS + 7) / 8) * 8;

  // stored slot word: start, wait, target, tag from the lowest bit up
  localparam int SLOT_W       = NOW_W + WAIT_W + ID_W + ID_W;

  typedef enum logic [KIND_W-1:0] {
    KIND_REQUEST = 2'd0,
    KIND_CANCEL  = 2'd1,
    KIND_POLL    = 2'd2
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_ACCEPTED   = 3'd0,
    ST_FULL       = 3'd1,
    ST_REJECTED   = 3'd2,
    ST_CANCELLED  = 3'd3,
    ST_NOT_FOUND  = 3'd4,
    ST_DISPATCHED = 3'd5,
    ST_NONE_DUE   = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE = 2'd0,
    FSM_WALK = 2'd1,
    FSM_FIN  = 2'd2
  } state_e;

  // one result item without its last flag
  typedef struct packed {
    status_e              status;
    logic [HANDLE_W-1:0]  handle;
    logic [ID_W-1:0]      target;
    logic [ID_W-1:0]      tag;
  } res_t;

endpackage

`default_nettype wire

### hw/rtl/tet_ram.sv
// ----------------------------------------------------------------------------
// tet_ram: generic single-write, single-read synchronous RAM
// One write port, one read port with read enable and registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tet_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, holds while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/timed_event_table.sv
// ----------------------------------------------------------------------------
// timed_event_table: table of pending timed events
// Stores requests in free slots, keeps their insertion order in a memory and
// on a poll removes and emits up to MAX_RES due entries in that order.
//
//   channel  | dir | tuser        | tdata                                   | tlast
//   s_axis   | in  | kind         | now, wait, target, tag, immediate, hdl  | -
//   m_axis   | out | status       | handle, target, tag                     | last
//
// Request, rejected request and cancel of a free slot: the item moves straight
// to the final state, which loads the result once the output register is free.
// Poll and cancel of a pending slot: the walk reads the order-list memory and
// then the slot memory, one entry per cycle while not stalled, and then the
// final state loads the result. A new item is taken only in idle, afterwards.
// A full output register stalls the walk only when a due entry after the first is
// dispatched; the final result waits for a free output register the same way.
// Reset clears the valid bits and the count; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module timed_event_table #(
  parameter int SLOTS = tet_pkg::SLOTS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // tdata: now_ms, wait_ms, target_id, event_tag, immediate, handle_in
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [tet_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: kind
  input  wire logic [tet_pkg::KIND_W-1:0]     s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // tdata: handle_out, target_out, tag_out
  output logic      [tet_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // tuser: status
  output logic      [tet_pkg::STATUS_W-1:0]   m_axis_tuser,
  output logic                                m_axis_tlast
);

  import tet_pkg::*;

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  // input fields
  kind_e               in_kind;
  logic [NOW_W-1:0]    in_now;
  logic [WAIT_W-1:0]   in_wait;
  logic [ID_W-1:0]     in_target;
  logic [ID_W-1:0]     in_tag;
  logic                in_imm;
  logic [HANDLE_W-1:0] in_hin;

  assign in_kind   = kind_e'(s_axis_tuser);
  assign in_now    = s_axis_tdata[IN_NOW_LO +: NOW_W];
  assign in_wait   = s_axis_tdata[IN_WAIT_LO +: WAIT_W];
  assign in_target = s_axis_tdata[IN_TGT_LO +: ID_W];
  assign in_tag    = s_axis_tdata[IN_TAG_LO +: ID_W];
  assign in_imm    = s_axis_tdata[IN_IMM_LO];
  assign in_hin    = s_axis_tdata[IN_HDL_LO +: HANDLE_W];

  // control state
  state_e           st_q, st_d;
  logic [SLOTS-1:0] valid_q, valid_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [CW-1:0]    idx_q, idx_d;
  logic [CW-1:0]    keep_q, keep_d;
  logic [N_W-1:0]   n_q, n_d;
  logic             v1_q, v1_d;
  logic             v2_q, v2_d;
  logic             out_valid_q;

  // item context and walk payload
  kind_e            kind_q, kind_d;
  logic [NOW_W-1:0] now_q, now_d;
  logic [SW-1:0]    hin_q, hin_d;
  logic [SW-1:0]    s2_q, s2_d;
  res_t             held_q, held_d;
  res_t             out_res_q;
  logic             out_last_q;

  // memory ports
  logic              ord_we, ord_re;
  logic [SW-1:0]     ord_waddr, ord_wdata, ord_rdata;
  logic              dat_we, dat_re;
  logic [SLOT_W-1:0] dat_wdata, dat_rdata;

  // misc combinational
  logic          out_free, out_load, out_last_d;
  logic [SW-1:0] free_idx;
  logic          free_found;
  logic          hin_ok;
  logic [SW-1:0] hin_idx;
  logic [NOW_W-1:0] elapsed;
  logic          due, dispatch, remove, adv;

  // lowest free slot
  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (!valid_q[k]) begin
        free_idx   = SW'(k);
        free_found = 1'b1;
      end
    end
  end

  assign hin_idx = SW'(in_hin);
  assign hin_ok  = (32'(in_hin) < 32'(SLOTS));

  // due check on the slot word read for the entry in the last walk stage
  assign elapsed  = now_q - dat_rdata[NOW_W-1:0];
  assign due      = !elapsed[NOW_W-1] &&
                    (elapsed[WAIT_W-1:0] > dat_rdata[NOW_W +: WAIT_W]);
  assign dispatch = (kind_q == KIND_POLL) && due && (n_q < N_W'(MAX_RES));
  assign remove   = (kind_q == KIND_POLL) ? dispatch : (s2_q == hin_q);

  assign out_free = !out_valid_q || m_axis_tready;

  // next state, walk pipeline and memory control
  always_comb begin
    st_d       = st_q;
    valid_d    = valid_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    keep_d     = keep_q;
    n_d        = n_q;
    v1_d       = v1_q;
    v2_d       = v2_q;
    kind_d     = kind_q;
    now_d      = now_q;
    hin_d      = hin_q;
    s2_d       = s2_q;
    held_d     = held_q;
    out_load   = 1'b0;
    out_last_d = 1'b0;
    s_axis_tready = 1'b0;
    adv        = 1'b0;
    ord_we     = 1'b0;
    ord_waddr  = cnt_q[SW-1:0];
    ord_wdata  = free_idx;
    ord_re     = 1'b0;
    dat_we     = 1'b0;
    dat_re     = 1'b0;
    dat_wdata  = {in_tag, in_target, in_wait, in_now};

    unique case (st_q)
      FSM_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          kind_d = in_kind;
          now_d  = in_now;
          hin_d  = hin_idx;
          idx_d  = '0;
          keep_d = '0;
          n_d    = '0;
          v1_d   = 1'b0;
          v2_d   = 1'b0;
          held_d = '{status: ST_NONE_DUE, handle: '0, target: '0, tag: '0};
          unique case (in_kind)
            KIND_REQUEST: begin
              st_d = FSM_FIN;
              if (in_imm) begin
                held_d.status = ST_REJECTED;
              end else if (!free_found) begin
                held_d.status = ST_FULL;
              end else begin
                held_d.status = ST_ACCEPTED;
                held_d.handle = HANDLE_W'(free_idx);
                valid_d[free_idx] = 1'b1;
                dat_we = 1'b1;
                ord_we = 1'b1;
                cnt_d  = cnt_q + CW'(1);
              end
            end
            KIND_CANCEL: begin
              held_d.handle = in_hin;
              if (hin_ok && valid_q[hin_idx]) begin
                held_d.status = ST_CANCELLED;
                valid_d[hin_idx] = 1'b0;
                st_d = FSM_WALK;
              end else begin
                held_d.status = ST_NOT_FOUND;
                st_d = FSM_FIN;
              end
            end
            KIND_POLL: begin
              st_d = FSM_WALK;
            end
            default: begin
              st_d = FSM_IDLE;
            end
          endcase
        end
      end

      FSM_WALK: begin
        // every dispatch after the first pushes the held result out first
        adv = !(v2_q && dispatch && (n_q != '0) && !out_free);
        if (adv) begin
          // stage 1: order list read
          ord_re = (idx_q < cnt_q);
          v1_d   = ord_re;
          if (ord_re) begin
            idx_d = idx_q + CW'(1);
          end
          // stage 2: slot read
          dat_re = v1_q;
          s2_d   = ord_rdata;
          v2_d   = v1_q;
          // stage 3: remove or keep
          if (v2_q) begin
            if (remove) begin
              if (kind_q == KIND_POLL) begin
                valid_d[s2_q] = 1'b0;
                n_d = n_q + N_W'(1);
                if (n_q != '0) begin
                  out_load = 1'b1;
                end
                held_d = '{status: ST_DISPATCHED,
                           handle: HANDLE_W'(s2_q),
                           target: dat_rdata[NOW_W + WAIT_W +: ID_W],
                           tag:    dat_rdata[NOW_W + WAIT_W + ID_W +: ID_W]};
              end
            end else begin
              ord_we    = 1'b1;
              ord_waddr = keep_q[SW-1:0];
              ord_wdata = s2_q;
              keep_d    = keep_q + CW'(1);
            end
          end
        end
        if ((idx_q == cnt_q) && !v1_q && !v2_q) begin
          cnt_d = keep_q;
          st_d  = FSM_FIN;
        end
      end

      FSM_FIN: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_last_d = 1'b1;
          st_d       = FSM_IDLE;
        end
      end

      default: begin
        st_d = FSM_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= FSM_IDLE;
      valid_q     <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
      keep_q      <= '0;
      n_q         <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      kind_q      <= KIND_REQUEST;
      out_valid_q <= 1'b0;
    end else begin
      st_q    <= st_d;
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      keep_q  <= keep_d;
      n_q     <= n_d;
      v1_q    <= v1_d;
      v2_q    <= v2_d;
      kind_q  <= kind_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    now_q  <= now_d;
    hin_q  <= hin_d;
    s2_q   <= s2_d;
    held_q <= held_d;
    if (out_load) begin
      out_res_q  <= held_q;
      out_last_q <= out_last_d;
    end
  end

  // insertion order memory
  tet_ram #(
    .WIDTH (SW),
    .DEPTH (SLOTS),
    .AW    (SW)
  ) u_order_ram (
    .clk_i   (clk_i),
    .we_i    (ord_we),
    .waddr_i (ord_waddr),
    .wdata_i (ord_wdata),
    .re_i    (ord_re),
    .raddr_i (idx_q[SW-1:0]),
    .rdata_o (ord_rdata)
  );

  // slot contents memory
  tet_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (SLOTS),
    .AW    (SW)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (dat_we),
    .waddr_i (free_idx),
    .wdata_i (dat_wdata),
    .re_i    (dat_re),
    .raddr_i (ord_rdata),
    .rdata_o (dat_rdata)
  );

  // output channel
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_res_q.status;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {(OUT_DATA_W - OUT_BITS)'(0), out_res_q.tag,
                          out_res_q.target, out_res_q.handle};

`ifndef NO_ASSERTIONS
  // between items the order list length matches the pending slots
  a_count_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == FSM_IDLE) |-> ($countones(valid_q) == 32'(cnt_q)))
    else $error("pending count differs from valid slots");

  // the walk pipeline is drained outside the walk
  a_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != FSM_WALK) |-> (!v1_q && !v2_q))
    else $error("walk stages busy outside walk");

  // a poll never dispatches more than the limit
  a_dispatch_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= N_W'(MAX_RES))
    else $error("dispatch count above limit");

  // a walk never leaves more entries than it started with
  a_walk_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((st_q == FSM_WALK) && (st_d == FSM_FIN)) |=> (cnt_q <= $past(cnt_q)))
    else $error("walk grew the order list");
`endif

endmodule

`default_nettype wire
